// ----- hw/rtl/xbg_pkg.sv -----
// Shared constants, state encoding and helpers for the xoroshiro128+ generator core.
package xbg_pkg;

	localparam logic [63:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] SM_MUL_A = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] SM_MUL_B = 64'h94d0_49bb_1331_11eb;

	localparam logic [1:0] REQ_SEED  = 2'd0;
	localparam logic [1:0] REQ_RAW   = 2'd1;
	localparam logic [1:0] REQ_BOUND = 2'd2;

	localparam logic [1:0] PH_LAST = 2'd2;
	localparam logic [4:0] DIV_LAST = 5'd31;

	typedef enum logic [8:0] {
		S_BOOT = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_MIXA = 9'b000000100,
		S_MIXB = 9'b000001000,
		S_ADV  = 9'b000010000,
		S_MUL  = 9'b000100000,
		S_CHK  = 9'b001000000,
		S_DIV  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	function automatic logic [63:0] mix_pre(input logic [63:0] x);
		return x ^ (x >> 30);
	endfunction

endpackage

// ----- hw/rtl/xoroshiro128plus_bounded_generator_core.sv -----
// xoroshiro128+ generator with splitmix64 seeding and bounded 32-bit draws.
// One word in, one word out. After reset the core seeds itself with zero
// (in_stall high). A seed computes two splitmix64 outputs, each two 64-bit
// multiplies built from three passes through one shared 32x32 multiplier.
// A bounded draw computes the rejection threshold by division (32-step
// restoring divider) when the first product's low half falls below the
// span, and draws a new candidate for each rejected one. One request in
// flight at a time; the core stalls its input until the result word is taken.
module xoroshiro128plus_bounded_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [63:0] seed_value,
	input  logic [31:0] low_bound,
	input  logic [31:0] high_bound,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] rand_value
);
	import xbg_pkg::*;

	state_t      state_q;
	logic [1:0]  phase_q;
	logic        word_sel_q;
	logic        boot_q;
	logic [1:0]  req_q;
	logic [63:0] w0_q;
	logic [63:0] w1_q;
	logic [63:0] sm_acc_q;
	logic [63:0] z_q;
	logic [63:0] prod_q;
	logic [31:0] span_q;
	logic [31:0] lo_q;
	logic [31:0] cand_q;
	logic [31:0] limit_q;
	logic        limit_ok_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [4:0]  div_cnt_q;
	logic [63:0] result_q;

	logic [63:0] mul_k;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] mix_sum;
	logic [63:0] adv_sum;
	logic [63:0] adv_b;
	logic [63:0] acc_next;
	logic [32:0] div_r;
	logic [63:0] mix_out;

	assign mul_k = (state_q == S_MIXB) ? SM_MUL_B : SM_MUL_A;

	always_comb begin
		mul_a = z_q[31:0];
		mul_b = mul_k[31:0];
		if (state_q == S_MUL) begin
			mul_a = cand_q;
			mul_b = span_q;
		end else if (phase_q == 2'd1) begin
			mul_b = mul_k[63:32];
		end else if (phase_q == PH_LAST) begin
			mul_a = z_q[63:32];
		end
	end

	assign mul_p    = 64'(mul_a) * 64'(mul_b);
	assign mix_sum  = prod_q + {mul_p[31:0], 32'h0};
	assign mix_out  = mix_sum ^ (mix_sum >> 31);
	assign adv_sum  = w0_q + w1_q;
	assign adv_b    = w0_q ^ w1_q;
	assign acc_next = sm_acc_q + SM_GAMMA;
	assign div_r    = {rem_q, dvd_q[31]};

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = (state_q == S_OUT);
	assign rand_value = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_BOOT;
			phase_q    <= '0;
			word_sel_q <= 1'b0;
			boot_q     <= 1'b1;
			limit_ok_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				S_BOOT: begin
					sm_acc_q   <= SM_GAMMA;
					z_q        <= mix_pre(SM_GAMMA);
					word_sel_q <= 1'b0;
					phase_q    <= '0;
					state_q    <= S_MIXA;
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q      <= req_type;
						lo_q       <= low_bound;
						span_q     <= high_bound - low_bound + 32'd1;
						limit_ok_q <= 1'b0;
						result_q   <= '0;
						phase_q    <= '0;
						word_sel_q <= 1'b0;
						sm_acc_q   <= seed_value + SM_GAMMA;
						z_q        <= mix_pre(seed_value + SM_GAMMA);
						unique case (req_type)
							REQ_SEED:  state_q <= S_MIXA;
							REQ_RAW:   state_q <= S_ADV;
							REQ_BOUND: state_q <= S_ADV;
							default:   state_q <= S_OUT;
						endcase
					end
				end
				S_MIXA, S_MIXB: begin
					if (phase_q == 2'd0) begin
						prod_q  <= mul_p;
						phase_q <= 2'd1;
					end else if (phase_q == 2'd1) begin
						prod_q  <= mix_sum;
						phase_q <= PH_LAST;
					end else begin
						phase_q <= '0;
						if (state_q == S_MIXA) begin
							z_q     <= mix_sum ^ (mix_sum >> 27);
							state_q <= S_MIXB;
						end else if (!word_sel_q) begin
							w0_q       <= mix_out;
							sm_acc_q   <= acc_next;
							z_q        <= mix_pre(acc_next);
							word_sel_q <= 1'b1;
							state_q    <= S_MIXA;
						end else begin
							w1_q   <= mix_out;
							boot_q <= 1'b0;
							state_q <= boot_q ? S_IDLE : S_OUT;
						end
					end
				end
				S_ADV: begin
					w0_q <= {w0_q[8:0], w0_q[63:9]} ^ adv_b ^ (adv_b << 14);
					w1_q <= {adv_b[27:0], adv_b[63:28]};
					if (req_q == REQ_RAW) begin
						result_q <= adv_sum;
						state_q  <= S_OUT;
					end else if (span_q == 32'd0) begin
						result_q <= {32'h0, lo_q + adv_sum[31:0]};
						state_q  <= S_OUT;
					end else begin
						cand_q  <= adv_sum[31:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= mul_p;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!limit_ok_q && (prod_q[31:0] < span_q)) begin
						rem_q     <= '0;
						dvd_q     <= 32'd0 - span_q;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end else if (limit_ok_q && (prod_q[31:0] < limit_q)) begin
						state_q <= S_ADV;
					end else begin
						result_q <= {32'h0, lo_q + prod_q[63:32]};
						state_q  <= S_OUT;
					end
				end
				S_DIV: begin
					dvd_q <= dvd_q << 1;
					if (div_r >= {1'b0, span_q}) begin
						rem_q <= 32'(div_r - {1'b0, span_q});
					end else begin
						rem_q <= div_r[31:0];
					end
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == DIV_LAST) begin
						limit_ok_q <= 1'b1;
						limit_q    <= (div_r >= {1'b0, span_q}) ?
							32'(div_r - {1'b0, span_q}) : div_r[31:0];
						state_q    <= S_CHK;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
